// ===== sv/rfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfb_pkg
// shared types, constants and the crc byte update for the rtu request framer
// ----------------------------------------------------------------------------
package rfb_pkg;

    localparam int HDR_BYTES   = 6;
    localparam int FRAME_BYTES = 8;
    localparam int BEAT_W      = $clog2(FRAME_BYTES);

    localparam logic       CMD_WRITE       = 1'b0;
    localparam logic       CMD_READ        = 1'b1;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [15:0] READ_COUNT     = 16'h0001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [15:0] crc;
    } crc_item_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/rfb_if.sv =====
// ----------------------------------------------------------------------------
// rfb interfaces
// request and frame byte channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface rfb_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  slave_address;
    logic [15:0] reg_address;
    logic [15:0] write_value;

    modport source (output valid, output cmd, output slave_address,
                    output reg_address, output write_value, input ready);
    modport sink   (input valid, input cmd, input slave_address,
                    input reg_address, input write_value, output ready);
endinterface

interface rfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== sv/rfb_crc_stage.sv =====
// ----------------------------------------------------------------------------
// rfb_crc_stage
// one pipeline stage: folds the leading header byte into the crc and rotates
// ----------------------------------------------------------------------------
module rfb_crc_stage
    import rfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  crc_item_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output crc_item_t out_data
);

    logic      valid_reg;
    crc_item_t data_reg;
    crc_item_t data_next;

    always_comb
    begin
        data_next.crc = crc_byte(in_data.crc, in_data.hdr[0]);
        data_next.hdr = {in_data.hdr[0], in_data.hdr[HDR_BYTES-1:1]};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== sv/rfb_serializer.sv =====
// ----------------------------------------------------------------------------
// rfb_serializer
// sends a finished frame one byte per beat, crc low byte first
// ----------------------------------------------------------------------------
module rfb_serializer
    import rfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  crc_item_t         in_data,
    rfb_frame_if.source       frame
);

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BYTES - 1);

    logic              busy_reg;
    logic [BEAT_W-1:0] cnt_reg;
    crc_item_t         item_reg;
    logic              is_last;
    logic              out_fire;

    assign is_last  = (cnt_reg == LAST_BEAT);
    assign out_fire = busy_reg && frame.ready;
    assign in_ready = !busy_reg || (frame.ready && is_last);

    assign frame.valid      = busy_reg;
    assign frame.frame_last = is_last;

    always_comb
    begin
        case (cnt_reg)
            3'd0:    frame.frame_byte = item_reg.hdr[0];
            3'd1:    frame.frame_byte = item_reg.hdr[1];
            3'd2:    frame.frame_byte = item_reg.hdr[2];
            3'd3:    frame.frame_byte = item_reg.hdr[3];
            3'd4:    frame.frame_byte = item_reg.hdr[4];
            3'd5:    frame.frame_byte = item_reg.hdr[5];
            3'd6:    frame.frame_byte = item_reg.crc[7:0];
            default: frame.frame_byte = item_reg.crc[15:8];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_ready && in_valid)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

endmodule

// ===== sv/rtu_request_frame_builder.sv =====
// ----------------------------------------------------------------------------
// rtu_request_frame_builder
// builds the 8-byte modbus rtu master frame for one register request
// ----------------------------------------------------------------------------
// req channel: one beat per request (write single register or read one
// holding register). frame channel: eight beats per request, slave address,
// function code, register address, value or count, then crc low and high;
// frame_last marks the crc high byte.
// the crc runs through six register stages, one header byte each, followed
// by the output serializer, which holds the frame and presents its bytes.
// requests enter one per cycle until the pipeline is full; sustained
// throughput is set by the one-byte-per-beat frame channel.
// reset clears all valid bits; nothing else needs clearing.
// when the receiver stalls, the current byte holds and the pipeline keeps
// filling, then req.ready drops once all seven frame slots are occupied.
// ----------------------------------------------------------------------------
module rtu_request_frame_builder
    import rfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rfb_req_if.sink     req,
    rfb_frame_if.source frame
);

    logic      stg_valid [HDR_BYTES+1];
    logic      stg_ready [HDR_BYTES+1];
    crc_item_t stg_data  [HDR_BYTES+1];

    always_comb
    begin
        stg_data[0].crc    = CRC_INIT;
        stg_data[0].hdr[0] = req.slave_address;
        stg_data[0].hdr[2] = req.reg_address[15:8];
        stg_data[0].hdr[3] = req.reg_address[7:0];
        if (req.cmd == CMD_READ)
        begin
            stg_data[0].hdr[1] = FC_READ_HOLDING;
            stg_data[0].hdr[4] = READ_COUNT[15:8];
            stg_data[0].hdr[5] = READ_COUNT[7:0];
        end
        else
        begin
            stg_data[0].hdr[1] = FC_WRITE_SINGLE;
            stg_data[0].hdr[4] = req.write_value[15:8];
            stg_data[0].hdr[5] = req.write_value[7:0];
        end
    end

    assign stg_valid[0] = req.valid;
    assign req.ready    = stg_ready[0];

    for (genvar i = 0; i < HDR_BYTES; i++)
    begin : g_crc
        rfb_crc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    rfb_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[HDR_BYTES]),
        .in_ready (stg_ready[HDR_BYTES]),
        .in_data  (stg_data[HDR_BYTES]),
        .frame    (frame)
    );

endmodule

// ===== sv/rfb_checker.sv =====
// ----------------------------------------------------------------------------
// rfb_checker
// port-level checks on request and frame beat accounting and on stalled beats
// ----------------------------------------------------------------------------
module rfb_checker
    import rfb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       frame_last
);

    localparam int SLOTS = HDR_BYTES + 1;

    logic              req_fire;
    logic              frame_fire;
    logic              frame_done;
    logic [BEAT_W-1:0] beat_reg;
    logic [3:0]        pending_reg;

    assign req_fire   = req_valid && req_ready;
    assign frame_fire = frame_valid && frame_ready;
    assign frame_done = frame_fire && frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (frame_fire)
            begin
                beat_reg <= beat_reg + 1'b1;
            end
            if (req_fire && !frame_done)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (!req_fire && frame_done)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_last_on_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame_last == (beat_reg == BEAT_W'(FRAME_BYTES - 1))))
        else $error("frame_last out of place");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (pending_reg != 4'd0))
        else $error("frame beat without a pending request");

    // a full pipeline only takes a request while the last byte leaves
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        ((pending_reg == 4'(SLOTS)) && !frame_done) |-> !req_ready)
        else $error("request taken with pipeline full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_ready) |=> (frame_valid && $stable(frame_byte)))
        else $error("stalled frame beat changed");

endmodule

bind rtu_request_frame_builder rfb_checker u_rfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .frame_last  (frame.frame_last)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for rtu_request_frame_builder
// sends write and read register requests with random gaps and checks every
// frame beat, byte and last flag against typed or locally built crc-16 frames;
// the frame channel stalls at random. directed rows run first, random follow
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfb_pkg::*;

    localparam int NUM_DIRECTED = 14;
    localparam int NUM_RANDOM   = 260;

    typedef struct {
        logic        cmd;
        logic [7:0]  slave_address;
        logic [15:0] reg_address;
        logic [15:0] write_value;
        bit          typed;
        logic [63:0] typed_frame;
    } req_row_t;

    typedef struct {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_beat_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   mismatch_count;

    frame_beat_t frame_expect_q [$];
    req_row_t    directed_rows [NUM_DIRECTED];

    rfb_req_if   req_bus ();
    rfb_frame_if frame_bus ();

    rtu_request_frame_builder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .frame (frame_bus.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // byte k of the frame sits at bits [63-8k -: 8]
    function automatic logic [63:0] build_frame(input logic cmd, input logic [7:0] slave,
                                                input logic [15:0] reg_addr,
                                                input logic [15:0] value);
        logic [47:0] hdr;
        logic [15:0] crc;
        logic [7:0]  b;
        hdr = {slave, (cmd == CMD_READ) ? FC_READ_HOLDING : FC_WRITE_SINGLE, reg_addr,
               (cmd == CMD_READ) ? READ_COUNT : value};
        crc = CRC_INIT;
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            b = hdr[47 - 8 * i -: 8];
            crc = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return {hdr, crc[7:0], crc[15:8]};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'h0000;
        end
        else if (r == 1)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    task automatic send_request(input req_row_t row);
        logic [63:0] frame_bits;
        int          gap;
        req_bus.valid         <= 1'b1;
        req_bus.cmd           <= row.cmd;
        req_bus.slave_address <= row.slave_address;
        req_bus.reg_address   <= row.reg_address;
        req_bus.write_value   <= row.write_value;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
        frame_bits = row.typed ? row.typed_frame
                   : build_frame(row.cmd, row.slave_address, row.reg_address,
                                 row.write_value);
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            frame_expect_q.push_back('{frame_bits[63 - 8 * k -: 8], k == FRAME_BYTES - 1});
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid         <= 1'b0;
            req_bus.cmd           <= 1'($urandom);
            req_bus.slave_address <= 8'($urandom);
            req_bus.reg_address   <= 16'($urandom);
            req_bus.write_value   <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // frame channel back-pressure
    initial
    begin
        frame_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int gap;
            frame_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                frame_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_bus.valid && frame_bus.ready)
        begin
            if (frame_expect_q.size() == 0)
            begin
                $error("unexpected frame beat: frame_byte %02h frame_last %0b",
                       frame_bus.frame_byte, frame_bus.frame_last);
                mismatch_count++;
            end
            else
            begin
                frame_beat_t want;
                want = frame_expect_q.pop_front();
                if (frame_bus.frame_byte !== want.frame_byte)
                begin
                    $error("frame_byte mismatch: expected %02h actual %02h",
                           want.frame_byte, frame_bus.frame_byte);
                    mismatch_count++;
                end
                if (frame_bus.frame_last !== want.frame_last)
                begin
                    $error("frame_last mismatch: expected %0b actual %0b",
                           want.frame_last, frame_bus.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        req_row_t row;
        mismatch_count = 0;
        quiet = 1'b0;
        rst_n <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.cmd           <= CMD_WRITE;
        req_bus.slave_address <= 8'h00;
        req_bus.reg_address   <= 16'h0000;
        req_bus.write_value   <= 16'h0000;

        // well-known frames typed in, the rest go through build_frame
        directed_rows = '{
            '{CMD_READ,  8'h01, 16'h0000, 16'h0000, 1'b1, 64'h01_03_00_00_00_01_84_0A},
            '{CMD_WRITE, 8'h01, 16'h0001, 16'h0003, 1'b1, 64'h01_06_00_01_00_03_98_0B},
            '{CMD_WRITE, 8'h00, 16'h0000, 16'h0000, 1'b0, 64'h0},
            '{CMD_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
            '{CMD_READ,  8'h00, 16'h0000, 16'hFFFF, 1'b0, 64'h0},
            '{CMD_READ,  8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
            '{CMD_READ,  8'hFF, 16'hFFFF, 16'h0000, 1'b0, 64'h0},
            '{CMD_WRITE, 8'hAA, 16'h5555, 16'hAAAA, 1'b0, 64'h0},
            '{CMD_WRITE, 8'h55, 16'hAAAA, 16'h5555, 1'b0, 64'h0},
            '{CMD_READ,  8'h80, 16'h8000, 16'h7FFF, 1'b0, 64'h0},
            '{CMD_WRITE, 8'h7F, 16'h7FFF, 16'h8000, 1'b0, 64'h0},
            '{CMD_WRITE, 8'h01, 16'h0001, 16'h0001, 1'b0, 64'h0},
            '{CMD_READ,  8'h01, 16'h0001, 16'h0001, 1'b0, 64'h0},
            '{CMD_WRITE, 8'hF7, 16'h00FF, 16'hFF00, 1'b0, 64'h0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_request(directed_rows[i]);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            quiet = (i >= 120 && i < 160);
            row.cmd           = 1'($urandom);
            row.slave_address = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                              : 8'($urandom);
            row.reg_address   = pick_word();
            row.write_value   = pick_word();
            row.typed         = 1'b0;
            row.typed_frame   = 64'h0;
            send_request(row);
        end
        quiet = 1'b0;

        req_bus.valid <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rfb_pkg.sv
sv/rfb_if.sv
sv/rfb_crc_stage.sv
sv/rfb_serializer.sv
sv/rtu_request_frame_builder.sv
sv/rfb_checker.sv
tb/testbench.sv
